FILE: src/mhpq_pkg.sv
// Shared constants and types of the max-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY    = 128;
  localparam int KEY_W       = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int COUNT_OUT_W = 8;
  localparam int STATUS_W    = 2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

endpackage

FILE: src/mhpq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write one word, read two words a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: src/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
// Keys live in a RAM in heap order; the key being moved is held in a register and written only
// at its final place. Raise start while busy is low to issue an insert or an extract; exactly
// one result word follows on out_* for a single cycle, marked by out_valid, and cannot be held
// off. An insert reads the parent and then climbs level by level (an insert into an empty heap
// writes the root at once). An extract reads the root and the tail key, loads them and then
// descends level by level (extracting the last key ends after the load). Each level is one
// read-compare-write pass through the RAM's registered read, so the depth of the heap, log2 of
// the capacity, sets the worst case. Refused operations (insert when full, extract when empty)
// answer in the cycle after start. A new command may be issued in the cycle the result is shown.
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_opcode,
  input  logic signed [KEY_W-1:0] in_key_in,
  output logic                   out_valid,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic [STATUS_W-1:0]    out_status,
  output logic [COUNT_OUT_W-1:0] out_count
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  key_t                key_r, key_nxt;
  key_t                res_key_r, res_key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  key_t                out_key_r, out_key_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  key_t              wdata;
  logic [ADDR_W-1:0] ra_addr, rb_addr;
  key_t              ra_data, rb_data;

  logic [ADDR_W-1:0] par, gpar, tail_par;
  logic [IDX_W-1:0]  lc, rc, cnt_ext, gc_l;
  logic [ADDR_W-1:0] child;
  logic              lv, rv, take_l, take_r;
  key_t              child_val;
  logic              full, empty;

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra_addr),
    .rdata_a (ra_data),
    .raddr_b (rb_addr),
    .rdata_b (rb_data)
  );

  // Index arithmetic around the current position
  always_comb begin
    full     = (cnt_r >= CNT_W'(CAPACITY));
    empty    = (cnt_r == '0);
    par      = (pos_r - ADDR_W'(1)) >> 1;
    gpar     = (par - ADDR_W'(1)) >> 1;
    tail_par = (ADDR_W'(cnt_r) - ADDR_W'(1)) >> 1;
    lc       = (IDX_W'(pos_r) << 1) + IDX_W'(1);
    rc       = lc + IDX_W'(1);
    cnt_ext  = IDX_W'(cnt_r);
    lv       = (lc < cnt_ext);
    rv       = (rc < cnt_ext);
    take_l   = lv && (ra_data > key_r);
    take_r   = rv && (rb_data > key_r) && (!take_l || (rb_data > ra_data));
    child     = take_r ? ADDR_W'(rc) : ADDR_W'(lc);
    child_val = take_r ? rb_data : ra_data;
    gc_l     = (IDX_W'(child) << 1) + IDX_W'(1);
  end

  // Sequence the sift and drive the RAM
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    res_key_nxt    = res_key_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = key_r;
    ra_addr        = '0;
    rb_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_INSERT) begin
            if (full) begin
              out_valid_nxt  = 1'b1;
              out_key_nxt    = '0;
              out_status_nxt = STAT_FULL;
            end else begin
              cnt_nxt     = cnt_r + CNT_W'(1);
              key_nxt     = in_key_in;
              res_key_nxt = '0;
              pos_nxt     = ADDR_W'(cnt_r);
              if (empty) begin
                we             = 1'b1;
                waddr          = '0;
                wdata          = in_key_in;
                out_valid_nxt  = 1'b1;
                out_key_nxt    = '0;
                out_status_nxt = STAT_OK;
              end else begin
                ra_addr   = tail_par;
                state_nxt = S_UP;
              end
            end
          end else begin
            if (empty) begin
              out_valid_nxt  = 1'b1;
              out_key_nxt    = '0;
              out_status_nxt = STAT_EMPTY;
            end else begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              ra_addr   = '0;
              rb_addr   = ADDR_W'(cnt_r - CNT_W'(1));
              state_nxt = S_LOAD;
            end
          end
        end
      end

      // Move the parent down while the new key is greater
      S_UP: begin
        we = 1'b1;
        if (key_r > ra_data) begin
          waddr   = pos_r;
          wdata   = ra_data;
          pos_nxt = par;
          ra_addr = gpar;
          if (par == '0) begin
            state_nxt = S_PUT;
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = '0;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end
      end

      // Drop the key into the root
      S_PUT: begin
        we             = 1'b1;
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_status_nxt = STAT_OK;
        state_nxt      = S_IDLE;
      end

      // Take the root as result and the tail key as the one to sift
      S_LOAD: begin
        res_key_nxt = ra_data;
        key_nxt     = rb_data;
        pos_nxt     = '0;
        if (empty) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = ra_data;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end else begin
          ra_addr   = ADDR_W'(1);
          rb_addr   = ADDR_W'(2);
          state_nxt = S_DOWN;
        end
      end

      // Pull the larger child up while it beats the held key
      S_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata   = child_val;
          pos_nxt = child;
          ra_addr = ADDR_W'(gc_l);
          rb_addr = ADDR_W'(gc_l + IDX_W'(1));
        end else begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = res_key_r;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    res_key_r    <= res_key_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;
  assign out_status  = out_status_r;
  assign out_count   = COUNT_OUT_W'(cnt_r);

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_FULL) |-> (cnt_r == CNT_W'(CAPACITY)))
    else $error("full refusal with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EMPTY) |-> (cnt_r == '0))
    else $error("empty refusal with keys held");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_INSERT && cnt_r < CNT_W'(CAPACITY))
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the max-heap priority queue: directed and random words, scoreboard.
module testbench;
  import mhpq_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1200;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum {PH_MIXED, PH_FILL, PH_DRAIN} phase_kind_t;

  typedef struct {
    logic        op;
    key_t        key;
    int unsigned gap;
    bit          drain;
  } heap_cmd_t;

  typedef struct {
    key_t                   key;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
  } heap_word_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  logic                   in_opcode = OP_INSERT;
  key_t                   in_key_in = '0;
  logic                   out_valid;
  key_t                   out_key_out;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_count;

  heap_cmd_t   cmd_q[$];
  heap_word_t  heap_answers_q[$];
  key_t        heap_img[CAPACITY];
  int unsigned heap_fill    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          calm_phase   = 1'b0;

  max_heap_priority_queue u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_key_in   (in_key_in),
    .out_valid   (out_valid),
    .out_key_out (out_key_out),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    key_t t;
    t = heap_img[a];
    heap_img[a] = heap_img[b];
    heap_img[b] = t;
  endfunction

  // Apply one operation to the shadow heap and return the word it should produce
  function automatic heap_word_t apply_heap_op(logic op, key_t key);
    heap_word_t  w;
    int unsigned pos;
    int unsigned nxt;
    int unsigned lc;
    int unsigned rc;
    bit          sinking;
    w.key = '0;
    w.status = STAT_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        w.status = STAT_FULL;
      end else begin
        pos = heap_fill;
        heap_img[pos] = key;
        heap_fill++;
        // climb while strictly greater than the parent
        while (pos > 0 && heap_img[pos] > heap_img[(pos - 1) / 2]) begin
          nxt = (pos - 1) / 2;
          swap_slots(pos, nxt);
          pos = nxt;
        end
      end
    end else if (heap_fill == 0) begin
      w.status = STAT_EMPTY;
    end else begin
      w.key = heap_img[0];
      heap_fill--;
      heap_img[0] = heap_img[heap_fill];
      // sink toward the strictly larger child, left one on a tie
      pos = 0;
      sinking = 1'b1;
      while (sinking) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        nxt = pos;
        if (lc < heap_fill && heap_img[lc] > heap_img[nxt]) nxt = lc;
        if (rc < heap_fill && heap_img[rc] > heap_img[nxt]) nxt = rc;
        if (nxt == pos) begin
          sinking = 1'b0;
        end else begin
          swap_slots(pos, nxt);
          pos = nxt;
        end
      end
    end
    w.count = COUNT_OUT_W'(heap_fill);
    return w;
  endfunction

  // Queue one word with a random lead-in gap, none in a calm phase
  function automatic void add_cmd(logic op, key_t key, bit drain);
    heap_cmd_t   c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.op = op;
    c.key = key;
    c.drain = drain;
    if (calm_phase || r < 55) c.gap = 0;
    else if (r < 85) c.gap = $urandom_range(1, 3);
    else if (r < 97) c.gap = $urandom_range(4, 12);
    else c.gap = $urandom_range(20, 60);
    cmd_q.push_back(c);
  endfunction

  // Driver: predict on acceptance, hold a word while busy, present the next one when free
  always @(posedge clk) begin
    heap_cmd_t nxt;
    bit        ready;
    ready = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) heap_answers_q.push_back(apply_heap_op(in_opcode, in_key_in));
      if (!(start && busy)) begin
        if (cmd_q.size() != 0 && cmd_q[0].gap != 0) begin
          cmd_q[0].gap = cmd_q[0].gap - 1;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && heap_answers_q.size() != 0)) begin
          ready = 1'b1;
        end
        if (ready) begin
          nxt = cmd_q.pop_front();
          start     <= 1'b1;
          in_opcode <= nxt.op;
          in_key_in <= nxt.key;
        end else begin
          start     <= 1'b0;
          in_opcode <= 1'($urandom);
          in_key_in <= key_t'($urandom);
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    heap_word_t exp_w;
    if (rst_n && out_valid) begin
      if (heap_answers_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected word: key %0d status %0d count %0d",
                   out_key_out, out_status, out_count);
      end else begin
        exp_w = heap_answers_q.pop_front();
        if (out_key_out !== exp_w.key || out_status !== exp_w.status ||
            out_count !== exp_w.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("mismatch: expected key %0d status %0d count %0d, got key %0d status %0d count %0d",
                     exp_w.key, exp_w.status, exp_w.count, out_key_out, out_status, out_count);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == TIMEOUT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    phase_kind_t kind;
    int unsigned phase;
    int unsigned total;
    int unsigned len;
    int unsigned ins_pct;
    int unsigned r;
    logic        op;
    key_t        k;

    // Directed: extract when empty, extreme and equal keys, drain to empty, left child on a tie
    add_cmd(OP_EXTRACT, 32'sh7FFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 32'sh8000_0000, 1'b0);
    add_cmd(OP_INSERT, 32'sh0000_0000, 1'b0);
    add_cmd(OP_INSERT, 32'shFFFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 32'sd1, 1'b0);
    add_cmd(OP_INSERT, 32'sd1, 1'b0);
    add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
    repeat (7) add_cmd(OP_EXTRACT, 32'shFFFF_FFFF, 1'b0);
    add_cmd(OP_EXTRACT, 32'sh8000_0000, 1'b0);
    add_cmd(OP_INSERT, 32'sd10, 1'b0);
    add_cmd(OP_INSERT, 32'sd7, 1'b0);
    add_cmd(OP_INSERT, 32'sd7, 1'b0);
    add_cmd(OP_INSERT, 32'sd1, 1'b0);
    repeat (4) add_cmd(OP_EXTRACT, key_t'($urandom), 1'b0);

    // Random phases: first a full fill and a full drain, then a mix
    total = 0;
    phase = 0;
    while (total < RANDOM_WORDS) begin
      if (phase == 0) kind = PH_FILL;
      else if (phase == 1) kind = PH_DRAIN;
      else begin
        r = $urandom_range(0, 5);
        kind = (r == 0) ? PH_FILL : (r == 1) ? PH_DRAIN : PH_MIXED;
      end
      case (kind)
        PH_FILL: begin
          len = $urandom_range(135, 160);
          ins_pct = (phase == 0) ? 100 : 90;
        end
        PH_DRAIN: begin
          len = $urandom_range(135, 160);
          ins_pct = (phase == 1) ? 0 : 10;
        end
        default: begin
          len = $urandom_range(40, 150);
          ins_pct = $urandom_range(30, 70);
        end
      endcase
      calm_phase = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
        r = $urandom_range(0, 9);
        if (r < 5) k = key_t'($urandom);
        else if (r < 8) k = key_t'($urandom_range(0, 16) - 8);
        else if (r == 8) k = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else k = key_t'($urandom_range(0, 3));
        // hold a phase's first word until the block has answered everything (phase 0, a third of the rest)
        add_cmd(op, k, (i == 0) && (phase == 0 || $urandom_range(0, 2) == 0));
      end
      total += len;
      phase++;
    end
    calm_phase = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (heap_answers_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && heap_answers_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/max_heap_priority_queue.sv
verif/testbench.sv
